[hdl/assert_macros.svh]
// assertion macros shared by the moment accumulator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WMTA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WMTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/wmta_pkg.sv]
// shared types and constants of the weighted moment tensor accumulator
// no dependencies; used by wmta_mul_sh and the top level
`timescale 1ns / 1ps

package wmta_pkg;

   localparam int VALUE_W     = 64;
   localparam int COORD_W     = 32;
   localparam int WEIGHT_W    = 16;
   localparam int ADDR_W      = 8;
   localparam int STORE_DEPTH = 256;
   localparam int DIGIT_W     = 2;
   localparam int LANES       = 4;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [2:0] CSR_ORDER    = 3'd0;
   localparam logic [2:0] CSR_CENTER_0 = 3'd1;
   localparam logic [2:0] CSR_CENTER_1 = 3'd2;
   localparam logic [2:0] CSR_CENTER_2 = 3'd3;
   localparam logic [2:0] CSR_CENTER_3 = 3'd4;

   localparam logic [2:0] ORDER_RESET = 3'd2;

   localparam logic [VALUE_W-1:0] MAG_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] MAG_MIN_NEG = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic                 start;
      logic [VALUE_W-1:0]   a_mag;
      logic                 a_neg;
      logic [COORD_W-1:0]   b_mag;
      logic                 b_neg;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [VALUE_W-1:0]   mag;
      logic                 neg;
   } mul_rsp_type;

endpackage

[hdl/wmta_mul_sh.sv]
// shared sign-magnitude multiply, shift right by 16 and saturate to 64 bits
// one 32x32 multiplier used for the low and high half; depends on wmta_pkg
`timescale 1ns / 1ps

module wmta_mul_sh (
   input  logic                 clock,
   input  logic                 reset,
   input  wmta_pkg::mul_req_type req,
   output wmta_pkg::mul_rsp_type rsp
);

   typedef enum logic [1:0] {MS_IDLE, MS_HI, MS_FIN} mstate_type;

   mstate_type state_ff, state_in;
   logic [31:0] a_hi_ff, a_hi_in;
   logic [31:0] b_ff, b_in;
   logic        neg_ff, neg_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] mag_ff, mag_in;
   logic        rneg_ff, rneg_in;
   logic        done_ff, done_in;

   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] mul_p;
   logic [63:0] r_sum;
   logic [63:0] r_sat;

   always_comb begin
      mul_x = (state_ff == MS_IDLE) ? req.a_mag[31:0] : a_hi_ff;
      mul_y = (state_ff == MS_IDLE) ? req.b_mag : b_ff;
      mul_p = {32'd0, mul_x} * {32'd0, mul_y};

      r_sum = {hi_ff[47:0], 16'd0} + {16'd0, lo_ff[63:16]};
      if (hi_ff[63:47] != 17'd0) begin
         r_sat = neg_ff ? wmta_pkg::MAG_MIN_NEG : wmta_pkg::MAG_MAX;
      end else if (!neg_ff && r_sum[63]) begin
         r_sat = wmta_pkg::MAG_MAX;
      end else if (neg_ff && r_sum[63] && (r_sum[62:0] != 63'd0)) begin
         r_sat = wmta_pkg::MAG_MIN_NEG;
      end else begin
         r_sat = r_sum;
      end
   end

   always_comb begin
      state_in = state_ff;
      a_hi_in  = a_hi_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mag_in   = mag_ff;
      rneg_in  = rneg_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MS_IDLE: begin
            if (req.start) begin
               lo_in    = mul_p;
               a_hi_in  = req.a_mag[63:32];
               b_in     = req.b_mag;
               neg_in   = req.a_neg ^ req.b_neg;
               state_in = MS_HI;
            end
         end
         MS_HI: begin
            hi_in    = mul_p;
            state_in = MS_FIN;
         end
         MS_FIN: begin
            mag_in   = r_sat;
            rneg_in  = neg_ff && (r_sat != 64'd0);
            done_in  = 1'b1;
            state_in = MS_IDLE;
         end
         default: state_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_hi_ff <= a_hi_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mag_ff  <= mag_in;
      rneg_ff <= rneg_in;
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.mag  = mag_ff;
   assign rsp.neg  = rneg_ff;

endmodule

[hdl/weighted_moment_tensor_accumulator.sv]
// sample: all D^n entries of order n are visited, D = DIMENSIONS; prefix products
//   are reused across levels, and each multiply runs on the shared unit
// read: index, memory read and response registered in turn; clear: drops all valid bits
// one request at a time; ready is low while a request is worked on
// reset: order 2, centers 0, all 256 entry valid bits cleared so entries read zero
// top level of the accumulator; depends on wmta_pkg, wmta_mul_sh, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_moment_tensor_accumulator #(
   parameter int DIMENSIONS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_coord_0,
   input  logic signed [31:0] req_coord_1,
   input  logic signed [31:0] req_coord_2,
   input  logic signed [31:0] req_coord_3,
   input  logic [15:0]        req_weight,
   input  logic [7:0]         req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_entry_value,
   output logic [7:0]         rsp_entry_index,
   output logic               rsp_index_valid,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam logic [8:0] COUNT_1 = 9'(DIMENSIONS);
   localparam logic [8:0] COUNT_2 = 9'(DIMENSIONS * DIMENSIONS);
   localparam logic [8:0] COUNT_3 = 9'(DIMENSIONS * DIMENSIONS * DIMENSIONS);
   localparam logic [8:0] COUNT_4 = 9'(DIMENSIONS * DIMENSIONS * DIMENSIONS * DIMENSIONS);
   localparam logic [wmta_pkg::DIGIT_W-1:0] DIG_LAST = wmta_pkg::DIGIT_W'(DIMENSIONS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_MUL, ST_WAIT, ST_ACC, ST_RD_WAIT, ST_RD_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]               moment_order_ff, moment_order_in;
   logic signed [31:0]       center_ff [wmta_pkg::LANES];
   logic signed [31:0]       center_in [wmta_pkg::LANES];
   logic [2:0]               ord_ff, ord_in;
   logic [15:0]              w_ff, w_in;
   logic signed [31:0]       x_ff [wmta_pkg::LANES];
   logic signed [31:0]       x_in [wmta_pkg::LANES];
   logic [31:0]              fac_mag_ff [wmta_pkg::LANES];
   logic [31:0]              fac_mag_in [wmta_pkg::LANES];
   logic                     fac_neg_ff [wmta_pkg::LANES];
   logic                     fac_neg_in [wmta_pkg::LANES];
   logic [wmta_pkg::DIGIT_W-1:0] dig_ff [wmta_pkg::LANES];
   logic [wmta_pkg::DIGIT_W-1:0] dig_in [wmta_pkg::LANES];
   logic [63:0]              stk_mag_ff [wmta_pkg::LANES];
   logic [63:0]              stk_mag_in [wmta_pkg::LANES];
   logic                     stk_neg_ff [wmta_pkg::LANES];
   logic                     stk_neg_in [wmta_pkg::LANES];
   logic [1:0]               lvl_ff, lvl_in;
   logic [63:0]              term_mag_ff, term_mag_in;
   logic                     term_neg_ff, term_neg_in;
   logic [7:0]               idx_ff, idx_in;
   logic                     idx_ok_ff, idx_ok_in;
   logic [wmta_pkg::STORE_DEPTH-1:0] entry_valid_ff, entry_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [63:0]              rsp_value_ff, rsp_value_in;
   logic [7:0]               rsp_index_ff, rsp_index_in;
   logic                     rsp_ivalid_ff, rsp_ivalid_in;

   logic [63:0] moment_store_mem [wmta_pkg::STORE_DEPTH];
   logic [63:0] rd_data_ff;
   logic        rd_valid_ff;
   logic [wmta_pkg::ADDR_W-1:0] raddr;
   logic        mem_we;
   logic [63:0] mem_wdata;

   logic [2:0]  ord_eff;
   logic [8:0]  req_count;
   logic [9:0]  addr_acc;
   logic [wmta_pkg::ADDR_W-1:0] entry_addr;
   logic [wmta_pkg::DIGIT_W-1:0] dig_next [wmta_pkg::LANES];
   logic        odo_carry;
   logic [1:0]  odo_stop;
   logic [32:0] diff [wmta_pkg::LANES];
   logic [31:0] lane_val [wmta_pkg::LANES];
   logic [63:0] old_val;
   logic [63:0] addend;
   logic [63:0] sum_raw;
   logic [63:0] acc_sum;
   logic        req_fire;

   wmta_pkg::mul_req_type mul_req;
   wmta_pkg::mul_rsp_type mul_rsp;

   wmta_mul_sh u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // order decode and entry count
   always_comb begin
      case (moment_order_ff) inside
         3'd0:          ord_eff = 3'd1;
         [3'd1:3'd4]:   ord_eff = moment_order_ff;
         default:       ord_eff = 3'd4;
      endcase
      unique case (ord_eff)
         3'd1:    req_count = COUNT_1;
         3'd2:    req_count = COUNT_2;
         3'd3:    req_count = COUNT_3;
         default: req_count = COUNT_4;
      endcase
   end

   // flattened index, digit 0 least significant
   always_comb begin
      addr_acc = 10'(dig_ff[3]);
      addr_acc = 10'(addr_acc * 10'(DIMENSIONS)) + 10'(dig_ff[2]);
      addr_acc = 10'(addr_acc * 10'(DIMENSIONS)) + 10'(dig_ff[1]);
      addr_acc = 10'(addr_acc * 10'(DIMENSIONS)) + 10'(dig_ff[0]);
      entry_addr = addr_acc[wmta_pkg::ADDR_W-1:0];
   end

   // odometer, last digit of the order runs fastest
   always_comb begin
      odo_carry = 1'b1;
      odo_stop  = 2'd0;
      dig_next  = dig_ff;
      for (int k = wmta_pkg::LANES - 1; k >= 0; k--) begin
         if (odo_carry && (3'(k) < ord_ff)) begin
            if (dig_ff[k] == DIG_LAST) begin
               dig_next[k] = '0;
            end else begin
               dig_next[k] = dig_ff[k] + 1'b1;
               odo_carry   = 1'b0;
               odo_stop    = 2'(k);
            end
         end
      end
   end

   // centered and saturated factors; order 1 uses the raw coordinates
   always_comb begin
      for (int k = 0; k < wmta_pkg::LANES; k++) begin
         diff[k] = {x_ff[k][31], x_ff[k]} - {center_ff[k][31], center_ff[k]};
         if (ord_ff == 3'd1) begin
            lane_val[k] = x_ff[k];
         end else if (diff[k][32] != diff[k][31]) begin
            lane_val[k] = diff[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            lane_val[k] = diff[k][31:0];
         end
      end
   end

   // saturating accumulate of the sign-magnitude term
   always_comb begin
      old_val = rd_valid_ff ? rd_data_ff : 64'd0;
      addend  = term_mag_ff ^ {64{term_neg_ff}};
      sum_raw = old_val + addend + 64'(term_neg_ff);
      if (!old_val[63] && !term_neg_ff && sum_raw[63]) begin
         acc_sum = wmta_pkg::MAG_MAX;
      end else if (old_val[63] && term_neg_ff && !sum_raw[63]) begin
         acc_sum = wmta_pkg::MAG_MIN_NEG;
      end else begin
         acc_sum = sum_raw;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign raddr     = (state_ff == ST_RD_WAIT || state_ff == ST_RD_OUT) ? idx_ff : entry_addr;
   assign mem_we    = (state_ff == ST_ACC);
   assign mem_wdata = acc_sum;

   always_comb begin
      mul_req.start = (state_ff == ST_MUL);
      mul_req.a_mag = stk_mag_ff[lvl_ff];
      mul_req.a_neg = stk_neg_ff[lvl_ff];
      mul_req.b_mag = fac_mag_ff[dig_ff[lvl_ff]];
      mul_req.b_neg = fac_neg_ff[dig_ff[lvl_ff]];
   end

   always_comb begin
      state_in        = state_ff;
      moment_order_in = moment_order_ff;
      center_in       = center_ff;
      ord_in          = ord_ff;
      w_in            = w_ff;
      x_in            = x_ff;
      fac_mag_in      = fac_mag_ff;
      fac_neg_in      = fac_neg_ff;
      dig_in          = dig_ff;
      stk_mag_in      = stk_mag_ff;
      stk_neg_in      = stk_neg_ff;
      lvl_in          = lvl_ff;
      term_mag_in     = term_mag_ff;
      term_neg_in     = term_neg_ff;
      idx_in          = idx_ff;
      idx_ok_in       = idx_ok_ff;
      entry_valid_in  = entry_valid_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_ivalid_in   = rsp_ivalid_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            wmta_pkg::CSR_ORDER:    moment_order_in = csr_write_data[2:0];
            wmta_pkg::CSR_CENTER_0: center_in[0] = signed'(csr_write_data);
            wmta_pkg::CSR_CENTER_1: center_in[1] = signed'(csr_write_data);
            wmta_pkg::CSR_CENTER_2: center_in[2] = signed'(csr_write_data);
            wmta_pkg::CSR_CENTER_3: center_in[3] = signed'(csr_write_data);
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  wmta_pkg::KIND_SAMPLE: begin
                     ord_in   = ord_eff;
                     w_in     = req_weight;
                     x_in[0]  = req_coord_0;
                     x_in[1]  = req_coord_1;
                     x_in[2]  = req_coord_2;
                     x_in[3]  = req_coord_3;
                     state_in = ST_PREP;
                  end
                  wmta_pkg::KIND_READ: begin
                     idx_in    = req_read_index;
                     idx_ok_in = {1'b0, req_read_index} < req_count;
                     state_in  = ST_RD_WAIT;
                  end
                  wmta_pkg::KIND_CLEAR: begin
                     entry_valid_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            for (int k = 0; k < wmta_pkg::LANES; k++) begin
               fac_neg_in[k] = lane_val[k][31];
               fac_mag_in[k] = lane_val[k][31] ? (~lane_val[k] + 32'd1) : lane_val[k];
               dig_in[k]     = '0;
            end
            stk_mag_in[0] = 64'(w_ff);
            stk_neg_in[0] = 1'b0;
            lvl_in        = 2'd0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_rsp.done) begin
               if ({1'b0, lvl_ff} + 3'd1 == ord_ff) begin
                  term_mag_in = mul_rsp.mag;
                  term_neg_in = mul_rsp.neg;
                  state_in    = ST_ACC;
               end else begin
                  stk_mag_in[lvl_ff + 2'd1] = mul_rsp.mag;
                  stk_neg_in[lvl_ff + 2'd1] = mul_rsp.neg;
                  lvl_in   = lvl_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_ACC: begin
            entry_valid_in[entry_addr] = 1'b1;
            if (odo_carry) begin
               state_in = ST_IDLE;
            end else begin
               dig_in   = dig_next;
               lvl_in   = odo_stop;
               state_in = ST_MUL;
            end
         end
         ST_RD_WAIT: begin
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (idx_ok_ff && rd_valid_ff) ? rd_data_ff : 64'd0;
               rsp_index_in  = idx_ff;
               rsp_ivalid_in = idx_ok_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      w_ff          <= w_in;
      x_ff          <= x_in;
      fac_mag_ff    <= fac_mag_in;
      fac_neg_ff    <= fac_neg_in;
      dig_ff        <= dig_in;
      stk_mag_ff    <= stk_mag_in;
      stk_neg_ff    <= stk_neg_in;
      lvl_ff        <= lvl_in;
      term_mag_ff   <= term_mag_in;
      term_neg_ff   <= term_neg_in;
      idx_ff        <= idx_in;
      idx_ok_ff     <= idx_ok_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_ivalid_ff <= rsp_ivalid_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         moment_order_ff <= wmta_pkg::ORDER_RESET;
         for (int k = 0; k < wmta_pkg::LANES; k++) begin
            center_ff[k] <= '0;
         end
         entry_valid_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         moment_order_ff <= moment_order_in;
         center_ff       <= center_in;
         entry_valid_ff  <= entry_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // accumulator store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         moment_store_mem[entry_addr] <= mem_wdata;
      end
      rd_data_ff  <= moment_store_mem[raddr];
      rd_valid_ff <= entry_valid_ff[raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = signed'(rsp_value_ff);
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_index_valid = rsp_ivalid_ff;

   `WMTA_ASSERT_IMPLIES(a_mul_done_in_wait, clock, reset, mul_rsp.done, state_ff == ST_WAIT, "multiply result outside wait")
   `WMTA_ASSERT_IMPLIES(a_acc_last_level, clock, reset, state_ff == ST_ACC, {1'b0, lvl_ff} + 3'd1 == ord_ff, "accumulate before last factor")
   `WMTA_ASSERT_IMPLIES(a_invalid_reads_zero, clock, reset, rsp_valid_ff && !rsp_ivalid_ff, rsp_value_ff == 64'd0, "out of range read not zero")

endmodule
